@@ rtl/i2c_buffered_master_slave_sequencer_top_defines.svh @@
// ----------------------------------------------------------------------------
// I2C sequencer assertion macros
// Concurrent assertion helpers used by the sequencer top module.
// ----------------------------------------------------------------------------
`ifndef I2C_BUFFERED_MASTER_SLAVE_SEQUENCER_TOP_DEFINES_SVH
`define I2C_BUFFERED_MASTER_SLAVE_SEQUENCER_TOP_DEFINES_SVH

// Checked on every clock edge, masked while reset is asserted.
`define I2CBMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define I2CBMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/i2cbms_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C sequencer package
// Request codes, action codes and the records passed between the modules.
// ----------------------------------------------------------------------------
package i2cbms_pkg;

  localparam int unsigned PktSizeDefault = 64;

  typedef enum logic [2:0] {
    REQ_BUS_EVENT    = 3'd0,
    REQ_LOAD_MASTER  = 3'd1,
    REQ_READ_MASTER  = 3'd2,
    REQ_START_MASTER = 3'd3,
    REQ_LOAD_SLAVE   = 3'd4,
    REQ_READ_SLAVE   = 3'd5,
    REQ_REARM_SLAVE  = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    START_NONE  = 2'd0,
    START_CLEAR = 2'd1,
    START_SET   = 2'd2
  } start_act_e;

  typedef enum logic [1:0] {
    STOP_NONE  = 2'd0,
    STOP_SET   = 2'd1,
    STOP_CLEAR = 2'd2
  } stop_act_e;

  // Where the driven byte comes from once the buffer reads are back.
  typedef enum logic [1:0] {
    DSRC_NONE = 2'd0,
    DSRC_ADDR = 2'd1,
    DSRC_MBUF = 2'd2,
    DSRC_SBUF = 2'd3
  } dsrc_e;

  typedef enum logic [1:0] {
    RSRC_NONE = 2'd0,
    RSRC_MBUF = 2'd1,
    RSRC_SBUF = 2'd2
  } rsrc_e;

  // Input item as it sits in tdata, lowest field last.
  typedef struct packed {
    logic [7:0] target_addr;
    logic [6:0] length;
    logic [7:0] value;
    logic [5:0] index;
    logic [7:0] bus_data;
    logic       tx_mode;
    logic       ack_seen;
    logic       stop_seen;
    logic       start_seen;
    logic       is_master;
    logic       arb_lost;
  } in_item_t;

  // Decision record from the core, before the buffer read data is merged.
  typedef struct packed {
    dsrc_e      data_src;
    logic [7:0] addr_byte;
    start_act_e start_action;
    stop_act_e  stop_action;
    logic       ack_set;
    logic       master_busy;
    logic       msg_received;
    logic [6:0] rx_count;
    rsrc_e      read_src;
  } decision_t;

  // Result item as it sits in tdata, lowest field last.
  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] rx_count;
    logic       msg_received;
    logic       master_busy;
    logic       ack_set;
    logic [1:0] stop_action;
    logic [1:0] start_action;
    logic [7:0] data_out;
    logic       data_valid;
  } out_item_t;

endpackage

@@ rtl/i2cbms_mem.sv @@
// ----------------------------------------------------------------------------
// I2C sequencer buffer memory
// One write port and one registered read port, both taken on enable.
// ----------------------------------------------------------------------------
module i2cbms_mem #(
  parameter int unsigned DEPTH = i2cbms_pkg::PktSizeDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/i2cbms_core.sv @@
// ----------------------------------------------------------------------------
// I2C sequencer decision core
// Holds the master and slave pointers, the master address and the message
// flag, and decides per request what the engine does next.
// ----------------------------------------------------------------------------
module i2cbms_core #(
  parameter int unsigned PKT_SIZE = i2cbms_pkg::PktSizeDefault,
  parameter int unsigned AW       = $clog2(PKT_SIZE),
  parameter int unsigned PW       = $clog2(PKT_SIZE + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  i2cbms_pkg::req_e      req_i,
  input  i2cbms_pkg::in_item_t  item_i,
  output i2cbms_pkg::decision_t dec_o,
  output logic                  mbuf_we_o,
  output logic [AW-1:0]         mbuf_waddr_o,
  output logic [7:0]            mbuf_wdata_o,
  output logic [AW-1:0]         mbuf_raddr_o,
  output logic                  sbuf_we_o,
  output logic [AW-1:0]         sbuf_waddr_o,
  output logic [7:0]            sbuf_wdata_o,
  output logic [AW-1:0]         sbuf_raddr_o
);

  logic [7:0]    maddr_q, maddr_d;
  logic [PW-1:0] mptr_q, mptr_d;
  logic [PW-1:0] mlen_q, mlen_d;
  logic [PW-1:0] sptr_q, sptr_d;
  logic          msg_q, msg_d;

  logic [PW-1:0] size_c;
  logic [PW-1:0] mptr_inc;
  logic [PW-1:0] sptr_inc;
  logic          m_room;
  logic          s_room;
  logic          idx_ok;
  logic [8:0]    idx_ext;

  assign size_c   = PW'(PKT_SIZE);
  assign mptr_inc = mptr_q + PW'(1);
  assign sptr_inc = sptr_q + PW'(1);
  assign m_room   = (mptr_q < mlen_q) && (mptr_q < size_c);
  // The slave length is only ever reset or rearmed to the buffer size.
  assign s_room   = sptr_q < size_c;
  assign idx_ok   = 32'(item_i.index) < PKT_SIZE;
  assign idx_ext  = 9'(item_i.index);

  always_comb begin
    maddr_d = maddr_q;
    mptr_d  = mptr_q;
    mlen_d  = mlen_q;
    sptr_d  = sptr_q;
    msg_d   = msg_q;

    dec_o              = '0;
    dec_o.data_src     = i2cbms_pkg::DSRC_NONE;
    dec_o.start_action = i2cbms_pkg::START_NONE;
    dec_o.stop_action  = i2cbms_pkg::STOP_NONE;
    dec_o.read_src     = i2cbms_pkg::RSRC_NONE;
    dec_o.addr_byte    = maddr_q;

    mbuf_we_o    = 1'b0;
    mbuf_waddr_o = mptr_q[AW-1:0];
    mbuf_wdata_o = item_i.bus_data;
    mbuf_raddr_o = mptr_q[AW-1:0];
    sbuf_we_o    = 1'b0;
    sbuf_waddr_o = sptr_q[AW-1:0];
    sbuf_wdata_o = item_i.bus_data;
    sbuf_raddr_o = sptr_q[AW-1:0];

    unique case (req_i)
      i2cbms_pkg::REQ_BUS_EVENT: begin
        priority if (item_i.arb_lost) begin
          dec_o.start_action = i2cbms_pkg::START_CLEAR;
          dec_o.stop_action  = i2cbms_pkg::STOP_CLEAR;
          dec_o.ack_set      = 1'b1;
        end else if (item_i.is_master) begin
          priority if (item_i.start_seen) begin
            dec_o.start_action = i2cbms_pkg::START_CLEAR;
            dec_o.stop_action  = i2cbms_pkg::STOP_CLEAR;
            dec_o.data_src     = i2cbms_pkg::DSRC_ADDR;
          end else if (item_i.ack_seen) begin
            if (maddr_q[0]) begin
              // Master read: store the byte and decide whether to ack more.
              if (m_room) begin
                mbuf_we_o = 1'b1;
                mptr_d    = mptr_inc;
                if (mptr_inc < mlen_q) begin
                  dec_o.ack_set = 1'b1;
                end else begin
                  maddr_d           = '0;
                  dec_o.stop_action = i2cbms_pkg::STOP_SET;
                end
              end else begin
                dec_o.stop_action = i2cbms_pkg::STOP_SET;
              end
            end else begin
              if (m_room) begin
                dec_o.data_src = i2cbms_pkg::DSRC_MBUF;
                mptr_d         = mptr_inc;
              end else begin
                maddr_d           = '0;
                dec_o.stop_action = i2cbms_pkg::STOP_SET;
              end
            end
          end else begin
            dec_o.stop_action = i2cbms_pkg::STOP_SET;
          end
        end else begin
          priority if (item_i.start_seen) begin
            dec_o.start_action = i2cbms_pkg::START_CLEAR;
            sptr_d             = '0;
            sbuf_raddr_o       = '0;
            if (item_i.bus_data[0]) begin
              dec_o.data_src = i2cbms_pkg::DSRC_SBUF;
              sptr_d         = PW'(1);
            end
          end else if (item_i.stop_seen) begin
            msg_d             = 1'b1;
            dec_o.stop_action = i2cbms_pkg::STOP_CLEAR;
          end else if (item_i.tx_mode) begin
            if (item_i.ack_seen && s_room) begin
              dec_o.data_src = i2cbms_pkg::DSRC_SBUF;
              sptr_d         = sptr_inc;
            end
          end else begin
            // Slave receive drops bytes once the buffer is full.
            if (s_room) begin
              sbuf_we_o = 1'b1;
              sptr_d    = sptr_inc;
              if (sptr_inc < size_c) begin
                dec_o.ack_set = 1'b1;
              end
            end
          end
        end
      end
      i2cbms_pkg::REQ_LOAD_MASTER: begin
        mbuf_we_o    = idx_ok;
        mbuf_waddr_o = idx_ext[AW-1:0];
        mbuf_wdata_o = item_i.value;
      end
      i2cbms_pkg::REQ_READ_MASTER: begin
        mbuf_raddr_o = idx_ext[AW-1:0];
        if (idx_ok) begin
          dec_o.read_src = i2cbms_pkg::RSRC_MBUF;
        end
      end
      i2cbms_pkg::REQ_START_MASTER: begin
        maddr_d = item_i.target_addr;
        mptr_d  = '0;
        if (32'(item_i.length) > PKT_SIZE) begin
          mlen_d = size_c;
        end else begin
          mlen_d = PW'(item_i.length);
        end
        dec_o.start_action = i2cbms_pkg::START_SET;
      end
      i2cbms_pkg::REQ_LOAD_SLAVE: begin
        sbuf_we_o    = idx_ok;
        sbuf_waddr_o = idx_ext[AW-1:0];
        sbuf_wdata_o = item_i.value;
      end
      i2cbms_pkg::REQ_READ_SLAVE: begin
        sbuf_raddr_o = idx_ext[AW-1:0];
        if (idx_ok) begin
          dec_o.read_src = i2cbms_pkg::RSRC_SBUF;
        end
      end
      i2cbms_pkg::REQ_REARM_SLAVE: begin
        sptr_d = '0;
        msg_d  = 1'b0;
      end
      default: begin
      end
    endcase

    dec_o.master_busy  = maddr_d != 8'd0;
    dec_o.msg_received = msg_d;
    dec_o.rx_count     = 7'(sptr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maddr_q <= '0;
      mptr_q  <= '0;
      mlen_q  <= '0;
      sptr_q  <= '0;
      msg_q   <= 1'b0;
    end else if (en_i) begin
      maddr_q <= maddr_d;
      mptr_q  <= mptr_d;
      mlen_q  <= mlen_d;
      sptr_q  <= sptr_d;
      msg_q   <= msg_d;
    end
  end

endmodule

@@ rtl/i2c_buffered_master_slave_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// I2C buffered master/slave sequencer
// Byte-level sequencer on top of an SMBus engine with master and slave
// buffers.
//
//   Channel  Dir  Moves                          Sideband
//   s_axis   in   bus event or host request      tuser = request code
//   m_axis   out  byte, actions and status       none
//
// One request is taken per cycle while input ready is high. The accepting
// edge updates the pointers, registers the decision and reads the buffer
// memories; the output register loads when the decision stage moves on.
// Reset clears pointers, address and flags at once; the buffers hold
// whatever was last written and need no clearing pass.
// The decision stage and the output register form a two-entry buffer, so
// input ready drops only while both are full and the output is stalled.
// ----------------------------------------------------------------------------
`include "i2c_buffered_master_slave_sequencer_top_defines.svh"

module i2c_buffered_master_slave_sequencer_top #(
  parameter int unsigned PKT_SIZE = i2cbms_pkg::PktSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // arb_lost, is_master, start_seen, stop_seen, ack_seen, tx_mode,
  // bus_data[13:6], index[19:14], value[27:20], length[34:28],
  // target_addr[42:35], zero fill
  input  logic [47:0] s_axis_tdata_i,
  // req_type
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // data_valid, data_out[8:1], start_action[10:9], stop_action[12:11],
  // ack_set[13], master_busy[14], msg_received[15], rx_count[22:16],
  // read_data[30:23], zero fill
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(PKT_SIZE);
  localparam int unsigned PW = $clog2(PKT_SIZE + 1);

  logic                  accept;
  logic                  s1_move;
  logic                  s1_valid_q;
  logic                  out_valid_q;
  i2cbms_pkg::decision_t dec;
  i2cbms_pkg::decision_t s1_q;
  i2cbms_pkg::out_item_t out_d;
  i2cbms_pkg::out_item_t out_q;
  i2cbms_pkg::in_item_t  item;

  logic          mbuf_we, sbuf_we;
  logic [AW-1:0] mbuf_waddr, mbuf_raddr, sbuf_waddr, sbuf_raddr;
  logic [7:0]    mbuf_wdata, sbuf_wdata, mbuf_rdata, sbuf_rdata;

  assign item            = i2cbms_pkg::in_item_t'(s_axis_tdata_i[42:0]);
  assign s1_move         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_move;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  i2cbms_core #(
    .PKT_SIZE (PKT_SIZE),
    .AW       (AW),
    .PW       (PW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .req_i        (i2cbms_pkg::req_e'(s_axis_tuser_i)),
    .item_i       (item),
    .dec_o        (dec),
    .mbuf_we_o    (mbuf_we),
    .mbuf_waddr_o (mbuf_waddr),
    .mbuf_wdata_o (mbuf_wdata),
    .mbuf_raddr_o (mbuf_raddr),
    .sbuf_we_o    (sbuf_we),
    .sbuf_waddr_o (sbuf_waddr),
    .sbuf_wdata_o (sbuf_wdata),
    .sbuf_raddr_o (sbuf_raddr)
  );

  i2cbms_mem #(
    .DEPTH (PKT_SIZE),
    .AW    (AW)
  ) u_mbuf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (mbuf_we),
    .waddr_i (mbuf_waddr),
    .wdata_i (mbuf_wdata),
    .raddr_i (mbuf_raddr),
    .rdata_o (mbuf_rdata)
  );

  i2cbms_mem #(
    .DEPTH (PKT_SIZE),
    .AW    (AW)
  ) u_sbuf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (sbuf_we),
    .waddr_i (sbuf_waddr),
    .wdata_i (sbuf_wdata),
    .raddr_i (sbuf_raddr),
    .rdata_o (sbuf_rdata)
  );

  // The memory read data registers update only on accept, so they stay
  // aligned with the decision held in s1_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= dec;
    end
  end

  always_comb begin
    out_d              = '0;
    out_d.start_action = s1_q.start_action;
    out_d.stop_action  = s1_q.stop_action;
    out_d.ack_set      = s1_q.ack_set;
    out_d.master_busy  = s1_q.master_busy;
    out_d.msg_received = s1_q.msg_received;
    out_d.rx_count     = s1_q.rx_count;
    unique case (s1_q.data_src)
      i2cbms_pkg::DSRC_NONE: out_d.data_out = 8'd0;
      i2cbms_pkg::DSRC_ADDR: out_d.data_out = s1_q.addr_byte;
      i2cbms_pkg::DSRC_MBUF: out_d.data_out = mbuf_rdata;
      i2cbms_pkg::DSRC_SBUF: out_d.data_out = sbuf_rdata;
      default:               out_d.data_out = 8'd0;
    endcase
    out_d.data_valid = s1_q.data_src != i2cbms_pkg::DSRC_NONE;
    unique case (s1_q.read_src)
      i2cbms_pkg::RSRC_MBUF: out_d.read_data = mbuf_rdata;
      i2cbms_pkg::RSRC_SBUF: out_d.read_data = sbuf_rdata;
      default:               out_d.read_data = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  `I2CBMS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result during reset")
  `I2CBMS_ASSERT(a_ready_low_only_full, !s_axis_tready_o |-> (s1_valid_q && out_valid_q), "input blocked with room left")
  `I2CBMS_ASSERT(a_rx_count_bound, m_axis_tvalid_o |-> (32'(out_q.rx_count) <= PKT_SIZE), "slave pointer past buffer end")
  `I2CBMS_ASSERT(a_idle_data_zero, (m_axis_tvalid_o && !out_q.data_valid) |-> (out_q.data_out == 8'd0), "data byte without data valid")

endmodule

@@ tb/sv/tb_i2c_buffered_master_slave_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// I2C buffered master/slave sequencer testbench
// Drives bus events and host accesses into the sequencer and checks every
// result against a cycle-free model of the buffers, pointers and flags. A
// short opening table covers the corner cases. Random master and slave
// transfers with host noise follow, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_i2c_buffered_master_slave_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufDepth   = i2cbms_pkg::PktSizeDefault;
  localparam int unsigned IdxW       = $clog2(BufDepth);
  localparam int unsigned ItemTarget = 1550;
  localparam logic [2:0]  ReqUnused  = 3'd7;

  typedef struct {
    logic [2:0]            req;
    i2cbms_pkg::in_item_t  it;
    bit                    typed;
    i2cbms_pkg::out_item_t want;
  } opening_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  // Model of the sequencer state.
  logic [7:0]  mbuf [BufDepth];
  logic [7:0]  sbuf [BufDepth];
  bit          mbuf_written [BufDepth];
  bit          sbuf_written [BufDepth];
  logic [7:0]  m_addr   = '0;
  int unsigned m_ptr    = 0;
  int unsigned m_len    = 0;
  int unsigned s_ptr    = 0;
  int unsigned s_len    = BufDepth;
  bit          msg_flag = 1'b0;

  i2cbms_pkg::out_item_t bus_actions_due [$];
  opening_row_t          opening_rows [$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;
  bit          hold_rx      = 1'b0;

  i2c_buffered_master_slave_sequencer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic i2cbms_pkg::in_item_t random_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(i2cbms_pkg::in_item_t)-1:0];
  endfunction

  function automatic i2cbms_pkg::in_item_t bus_ev(input logic arb, input logic mst,
                                                  input logic sta, input logic sto,
                                                  input logic ack, input logic txm,
                                                  input logic [7:0] data);
    i2cbms_pkg::in_item_t it;
    it = random_fields();
    it.arb_lost   = arb;
    it.is_master  = mst;
    it.start_seen = sta;
    it.stop_seen  = sto;
    it.ack_seen   = ack;
    it.tx_mode    = txm;
    it.bus_data   = data;
    return it;
  endfunction

  function automatic i2cbms_pkg::in_item_t host_req(input logic [5:0] idx,
                                                    input logic [7:0] val,
                                                    input logic [6:0] len,
                                                    input logic [7:0] addr);
    i2cbms_pkg::in_item_t it;
    it = random_fields();
    it.index       = idx;
    it.value       = val;
    it.length      = len;
    it.target_addr = addr;
    return it;
  endfunction

  function automatic i2cbms_pkg::out_item_t outcome(input logic dv, input logic [7:0] dout,
                                                    input i2cbms_pkg::start_act_e sa,
                                                    input i2cbms_pkg::stop_act_e so,
                                                    input logic ack, input logic busy,
                                                    input logic msg,
                                                    input logic [6:0] rx,
                                                    input logic [7:0] rd);
    i2cbms_pkg::out_item_t r;
    r.data_valid   = dv;
    r.data_out     = dout;
    r.start_action = sa;
    r.stop_action  = so;
    r.ack_set      = ack;
    r.master_busy  = busy;
    r.msg_received = msg;
    r.rx_count     = rx;
    r.read_data    = rd;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] req, input i2cbms_pkg::in_item_t it,
                                  input bit typed = 1'b0,
                                  input i2cbms_pkg::out_item_t want = '0);
    opening_row_t row;
    row.req   = req;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    opening_rows.push_back(row);
  endfunction

  // Tells whether a request would read a buffer entry that was never written,
  // and which entry that is.
  function automatic bit blank_read(input logic [2:0] req, input i2cbms_pkg::in_item_t it,
                                    output bit to_master, output int unsigned slot);
    to_master = 1'b0;
    slot      = 32'(it.index);
    case (req)
      i2cbms_pkg::REQ_READ_MASTER: begin
        to_master = 1'b1;
        return !mbuf_written[it.index];
      end
      i2cbms_pkg::REQ_READ_SLAVE: return !sbuf_written[it.index];
      i2cbms_pkg::REQ_BUS_EVENT: begin
        if (it.arb_lost) return 1'b0;
        if (it.is_master) begin
          to_master = 1'b1;
          slot      = m_ptr;
          return !it.start_seen && it.ack_seen && !m_addr[0] && m_ptr < m_len &&
                 !mbuf_written[m_ptr[IdxW-1:0]];
        end
        if (it.start_seen) begin
          slot = 0;
          return it.bus_data[0] && !sbuf_written[0];
        end
        slot = s_ptr;
        return !it.stop_seen && it.tx_mode && it.ack_seen && s_ptr < s_len &&
               !sbuf_written[s_ptr[IdxW-1:0]];
      end
      default: return 1'b0;
    endcase
  endfunction

  // Applies one request to the model and returns the actions and status.
  function automatic i2cbms_pkg::out_item_t sequence_item(input logic [2:0] req,
                                                          input i2cbms_pkg::in_item_t it);
    i2cbms_pkg::out_item_t r;
    r = '0;
    case (req)
      i2cbms_pkg::REQ_BUS_EVENT: begin
        if (it.arb_lost) begin
          r.start_action = i2cbms_pkg::START_CLEAR;
          r.stop_action  = i2cbms_pkg::STOP_CLEAR;
          r.ack_set      = 1'b1;
        end else if (it.is_master) begin
          if (it.start_seen) begin
            r.start_action = i2cbms_pkg::START_CLEAR;
            r.stop_action  = i2cbms_pkg::STOP_CLEAR;
            r.data_valid   = 1'b1;
            r.data_out     = m_addr;
          end else if (!it.ack_seen) begin
            r.stop_action = i2cbms_pkg::STOP_SET;
          end else if (m_addr[0]) begin
            if (m_ptr < m_len) begin
              mbuf[m_ptr[IdxW-1:0]]         = it.bus_data;
              mbuf_written[m_ptr[IdxW-1:0]] = 1'b1;
              m_ptr++;
              if (m_ptr < m_len) begin
                r.ack_set = 1'b1;
              end else begin
                m_addr        = '0;
                r.stop_action = i2cbms_pkg::STOP_SET;
              end
            end else begin
              r.stop_action = i2cbms_pkg::STOP_SET;
            end
          end else if (m_ptr < m_len) begin
            r.data_valid = 1'b1;
            r.data_out   = mbuf[m_ptr[IdxW-1:0]];
            m_ptr++;
          end else begin
            m_addr        = '0;
            r.stop_action = i2cbms_pkg::STOP_SET;
          end
        end else if (it.start_seen) begin
          r.start_action = i2cbms_pkg::START_CLEAR;
          s_ptr          = 0;
          if (it.bus_data[0]) begin
            r.data_valid = 1'b1;
            r.data_out   = sbuf[0];
            s_ptr        = 1;
          end
        end else if (it.stop_seen) begin
          msg_flag      = 1'b1;
          r.stop_action = i2cbms_pkg::STOP_CLEAR;
        end else if (it.tx_mode) begin
          if (it.ack_seen && s_ptr < s_len) begin
            r.data_valid = 1'b1;
            r.data_out   = sbuf[s_ptr[IdxW-1:0]];
            s_ptr++;
          end
        end else if (s_ptr < s_len) begin
          // Bytes past the end of the slave buffer are dropped.
          sbuf[s_ptr[IdxW-1:0]]         = it.bus_data;
          sbuf_written[s_ptr[IdxW-1:0]] = 1'b1;
          s_ptr++;
          if (s_ptr < s_len) r.ack_set = 1'b1;
        end
      end
      i2cbms_pkg::REQ_LOAD_MASTER: begin
        mbuf[it.index]         = it.value;
        mbuf_written[it.index] = 1'b1;
      end
      i2cbms_pkg::REQ_READ_MASTER: r.read_data = mbuf[it.index];
      i2cbms_pkg::REQ_START_MASTER: begin
        m_addr         = it.target_addr;
        m_ptr          = 0;
        m_len          = (32'(it.length) > BufDepth) ? BufDepth : 32'(it.length);
        r.start_action = i2cbms_pkg::START_SET;
      end
      i2cbms_pkg::REQ_LOAD_SLAVE: begin
        sbuf[it.index]         = it.value;
        sbuf_written[it.index] = 1'b1;
      end
      i2cbms_pkg::REQ_READ_SLAVE: r.read_data = sbuf[it.index];
      i2cbms_pkg::REQ_REARM_SLAVE: begin
        s_ptr    = 0;
        s_len    = BufDepth;
        msg_flag = 1'b0;
      end
      default: ;
    endcase
    r.master_busy  = (m_addr != '0);
    r.msg_received = msg_flag;
    r.rx_count     = s_ptr[6:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  task automatic check_result(input logic [31:0] word);
    i2cbms_pkg::out_item_t got;
    i2cbms_pkg::out_item_t want;
    got = word[$bits(i2cbms_pkg::out_item_t)-1:0];
    if (bus_actions_due.size() == 0) begin
      flag_mismatch("result with none pending", word, '0);
      return;
    end
    want = bus_actions_due.pop_front();
    if (got.data_valid !== want.data_valid)
      flag_mismatch("data_valid", 32'(got.data_valid), 32'(want.data_valid));
    if (got.data_out !== want.data_out)
      flag_mismatch("data_out", 32'(got.data_out), 32'(want.data_out));
    if (got.start_action !== want.start_action)
      flag_mismatch("start_action", 32'(got.start_action), 32'(want.start_action));
    if (got.stop_action !== want.stop_action)
      flag_mismatch("stop_action", 32'(got.stop_action), 32'(want.stop_action));
    if (got.ack_set !== want.ack_set)
      flag_mismatch("ack_set", 32'(got.ack_set), 32'(want.ack_set));
    if (got.master_busy !== want.master_busy)
      flag_mismatch("master_busy", 32'(got.master_busy), 32'(want.master_busy));
    if (got.msg_received !== want.msg_received)
      flag_mismatch("msg_received", 32'(got.msg_received), 32'(want.msg_received));
    if (got.rx_count !== want.rx_count)
      flag_mismatch("rx_count", 32'(got.rx_count), 32'(want.rx_count));
    if (got.read_data !== want.read_data)
      flag_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
    if (word[31] !== 1'b0)
      flag_mismatch("zero fill", 32'(word[31]), '0);
  endtask

  // Presents one request and returns at the edge that accepts it.
  task automatic offer(input logic [2:0] req, input i2cbms_pkg::in_item_t it);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {5'd0, it};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic issue(input logic [2:0] req, input i2cbms_pkg::in_item_t it,
                       input bit typed = 1'b0, input i2cbms_pkg::out_item_t want = '0);
    bit                    to_master;
    int unsigned           slot;
    i2cbms_pkg::out_item_t predicted;
    // A read of a blank entry becomes a load of that entry instead.
    if (blank_read(req, it, to_master, slot)) begin
      req      = to_master ? i2cbms_pkg::REQ_LOAD_MASTER : i2cbms_pkg::REQ_LOAD_SLAVE;
      it.index = 6'(slot);
      it.value = rnd_byte();
    end
    predicted = sequence_item(req, it);
    bus_actions_due.push_back(typed ? want : predicted);
    offer(req, it);
  endtask

  // Output side: random stalls, steady stretches, and the long hold-off.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        check_result(m_axis_tdata_o);
        if (results_seen % 97 == 0) rx_steady = !rx_steady;
        stall = rx_steady ? 0 : $urandom_range(0, 14);
      end else if (stall != 0) begin
        stall--;
      end
      m_axis_tready_i <= (stall == 0) && !hold_rx;
    end
  end

  // Holds the output long enough for the block to fill and stall its input.
  initial begin
    wait (items_sent >= 400);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #5ms;
    $display("i2c_buffered_master_slave_sequencer_top verification failed");
    $finish;
  end

  initial begin
    i2cbms_pkg::in_item_t it;
    logic [7:0]           a;
    int unsigned          len;
    int unsigned          steps;
    int unsigned          n;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(i2cbms_pkg::REQ_REARM_SLAVE, random_fields(), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_NONE, i2cbms_pkg::STOP_NONE,
                    1'b0, 1'b0, 1'b0, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT,
            bus_ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_CLEAR, i2cbms_pkg::STOP_CLEAR,
                    1'b1, 1'b0, 1'b0, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_LOAD_MASTER, host_req(6'd0, 8'h00, 7'd0, 8'h00), 1'b1, '0);
    add_row(i2cbms_pkg::REQ_LOAD_MASTER, host_req(6'd63, 8'hFF, 7'd127, 8'hFF), 1'b1, '0);
    add_row(i2cbms_pkg::REQ_READ_MASTER, host_req(6'd63, 8'h00, 7'd0, 8'h00), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_NONE, i2cbms_pkg::STOP_NONE,
                    1'b0, 1'b0, 1'b0, 7'd0, 8'hFF));
    add_row(i2cbms_pkg::REQ_READ_MASTER, host_req(6'd0, 8'hFF, 7'd0, 8'h00), 1'b1, '0);
    add_row(i2cbms_pkg::REQ_LOAD_SLAVE, host_req(6'd0, 8'hA5, 7'd0, 8'h00), 1'b1, '0);
    add_row(i2cbms_pkg::REQ_LOAD_SLAVE, host_req(6'd63, 8'h5A, 7'd0, 8'h00), 1'b1, '0);
    add_row(i2cbms_pkg::REQ_READ_SLAVE, host_req(6'd63, 8'h00, 7'd0, 8'h00), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_NONE, i2cbms_pkg::STOP_NONE,
                    1'b0, 1'b0, 1'b0, 7'd0, 8'h5A));
    // Read transfer with an oversized length, which saturates at the buffer size.
    add_row(i2cbms_pkg::REQ_START_MASTER, host_req(6'd0, 8'h00, 7'd127, 8'h81), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_SET, i2cbms_pkg::STOP_NONE,
                    1'b0, 1'b1, 1'b0, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT,
            bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
            outcome(1'b1, 8'h81, i2cbms_pkg::START_CLEAR, i2cbms_pkg::STOP_CLEAR,
                    1'b0, 1'b1, 1'b0, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h3C));
    // A missing acknowledge sets stop but keeps the master busy.
    add_row(i2cbms_pkg::REQ_BUS_EVENT,
            bus_ev(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00), 1'b1,
            outcome(1'b0, 8'h00, i2cbms_pkg::START_NONE, i2cbms_pkg::STOP_SET,
                    1'b0, 1'b1, 1'b0, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_START_MASTER, host_req(6'd5, 8'h00, 7'd1, 8'h02));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    // Zero-length read: the acknowledge only sets stop.
    add_row(i2cbms_pkg::REQ_START_MASTER, host_req(6'd0, 8'h00, 7'd0, 8'h03));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF));
    add_row(i2cbms_pkg::REQ_LOAD_SLAVE, host_req(6'd1, 8'h77, 7'd0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hC3));
    add_row(i2cbms_pkg::REQ_BUS_EVENT, bus_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    add_row(ReqUnused, random_fields());
    add_row(i2cbms_pkg::REQ_REARM_SLAVE, random_fields());

    foreach (opening_rows[i])
      issue(opening_rows[i].req, opening_rows[i].it, opening_rows[i].typed,
            opening_rows[i].want);

    while (items_sent < ItemTarget) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Master transfer, write or read, with the odd lost arbitration.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 127) : $urandom_range(0, 6);
          a = rnd_byte();
          a[0] = rnd_bit();
          issue(i2cbms_pkg::REQ_START_MASTER, host_req(6'($urandom), rnd_byte(), 7'(len), a));
          issue(i2cbms_pkg::REQ_BUS_EVENT,
                bus_ev(1'b0, 1'b1, 1'b1, rnd_bit(), rnd_bit(), rnd_bit(), rnd_byte()));
          steps = 0;
          while (m_addr != '0 && steps < 2 * m_len + 8) begin
            issue(i2cbms_pkg::REQ_BUS_EVENT,
                  bus_ev($urandom_range(0, 19) == 0, 1'b1, 1'b0, rnd_bit(),
                         $urandom_range(0, 11) != 0, rnd_bit(), rnd_byte()));
            steps++;
          end
        end
        4, 5: begin
          // Slave receive, sometimes running past the end of the buffer.
          a = rnd_byte();
          a[0] = 1'b0;
          issue(i2cbms_pkg::REQ_BUS_EVENT,
                bus_ev(1'b0, 1'b0, 1'b1, rnd_bit(), rnd_bit(), rnd_bit(), a));
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
          repeat (n)
            issue(i2cbms_pkg::REQ_BUS_EVENT,
                  bus_ev(1'b0, 1'b0, 1'b0, 1'b0, rnd_bit(), 1'b0, rnd_byte()));
          issue(i2cbms_pkg::REQ_BUS_EVENT,
                bus_ev(1'b0, 1'b0, 1'b0, 1'b1, rnd_bit(), rnd_bit(), rnd_byte()));
          repeat ($urandom_range(0, 3))
            issue(i2cbms_pkg::REQ_READ_SLAVE,
                  host_req(6'($urandom_range(0, 8)), rnd_byte(), 7'($urandom), rnd_byte()));
          if ($urandom_range(0, 9) < 7) issue(i2cbms_pkg::REQ_REARM_SLAVE, random_fields());
        end
        6: begin
          // Slave transmit from host-loaded bytes.
          repeat ($urandom_range(1, 4))
            issue(i2cbms_pkg::REQ_LOAD_SLAVE,
                  host_req(6'($urandom_range(0, 5)), rnd_byte(), 7'($urandom), rnd_byte()));
          a = rnd_byte();
          a[0] = 1'b1;
          issue(i2cbms_pkg::REQ_BUS_EVENT,
                bus_ev(1'b0, 1'b0, 1'b1, rnd_bit(), rnd_bit(), rnd_bit(), a));
          repeat ($urandom_range(0, 6))
            issue(i2cbms_pkg::REQ_BUS_EVENT,
                  bus_ev(1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 4) != 0, 1'b1,
                         rnd_byte()));
          issue(i2cbms_pkg::REQ_BUS_EVENT,
                bus_ev(1'b0, 1'b0, 1'b0, 1'b1, rnd_bit(), rnd_bit(), rnd_byte()));
          if ($urandom_range(0, 1) == 1) issue(i2cbms_pkg::REQ_REARM_SLAVE, random_fields());
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            it = random_fields();
            issue(3'($urandom_range(0, 7)), it);
          end
        end
      endcase
    end

    s_axis_tvalid_i <= 1'b0;
    while (bus_actions_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("i2c_buffered_master_slave_sequencer_top verification clean");
    end else begin
      $display("i2c_buffered_master_slave_sequencer_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/i2cbms_pkg.sv
rtl/i2cbms_mem.sv
rtl/i2cbms_core.sv
rtl/i2c_buffered_master_slave_sequencer_top.sv
tb/sv/tb_i2c_buffered_master_slave_sequencer_top.sv
